>>> hw/rtl/unique_color_palette_builder_unit_macros.svh
// Assertion macros shared by the palette builder RTL.
`ifndef UNIQUE_COLOR_PALETTE_BUILDER_UNIT_MACROS_SVH
`define UNIQUE_COLOR_PALETTE_BUILDER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define UCPB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define UCPB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/ucpb_pkg.sv
// Types and level conversion shared by the palette builder modules.
`default_nettype none

package ucpb_pkg;

  localparam logic [7:0] W_BIT0 = 8'h0e;
  localparam logic [7:0] W_BIT1 = 8'h1f;
  localparam logic [7:0] W_BIT2 = 8'h43;
  localparam logic [7:0] W_BIT3 = 8'h8f;

  typedef struct packed {
    logic [3:0] red_nibble;
    logic [3:0] green_nibble;
    logic [3:0] blue_nibble;
    logic       start_new;
  } in_item_t;

  typedef struct packed {
    logic [7:0] palette_index;
    logic       is_new;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
    logic       table_full;
  } out_item_t;

  // Search outcome handed from the sequencer to the output stage.
  typedef struct packed {
    logic [11:0] key;
    logic [7:0]  index8;
    logic        is_new;
    logic        full;
  } srch_res_t;

  // Sum of the resistor weights of the set bits; all four give 0xff exactly.
  function automatic logic [7:0] nibble_level(input logic [3:0] n);
    logic [7:0] v;
    v = 8'h00;
    if (n[0]) v = v + W_BIT0;
    if (n[1]) v = v + W_BIT1;
    if (n[2]) v = v + W_BIT2;
    if (n[3]) v = v + W_BIT3;
    return v;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/unique_color_palette_builder_unit.sv
// Top level of the unique colour palette builder: handshakes, level conversion, output register.
//
//   channel | direction | payload                    | transfer when
//   in_     | input     | ucpb_pkg::in_item_t        | in_valid && in_ready
//   out_    | output    | ucpb_pkg::out_item_t       | out_valid && out_ready
//
// A miss compares every used slot before its result is registered, a hit in slot j
//   stops the scan at that slot; the single table read port and the one comparator
//   examine one stored colour per cycle.
// in_ready is high only while the sequencer is idle; one item is worked at a time.
// A finished result waits in the output register; the next item may transfer meanwhile.
// rst_n is synchronous and clears the used count; table contents are not cleared.
`default_nettype none

`include "unique_color_palette_builder_unit_macros.svh"

module unique_color_palette_builder_unit #(
  parameter int TABLE_DEPTH = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire ucpb_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output ucpb_pkg::out_item_t       out_data
);

  logic                 srch_idle;
  logic                 res_valid;
  ucpb_pkg::srch_res_t  res;
  logic                 slot_free;
  logic                 load;
  logic                 in_acc;
  logic                 out_valid_r;
  ucpb_pkg::out_item_t  out_data_r, out_data_nxt;

  // Accept only while the sequencer has nothing in flight.
  assign in_ready  = srch_idle;
  assign in_acc    = in_valid && in_ready;

  // Output slot is free when empty or being drained this cycle.
  assign slot_free = !out_valid_r || out_ready;
  assign load      = res_valid && slot_free;

  ucpb_search #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_search (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc_i       (in_acc),
    .key_i       ({in_data.red_nibble, in_data.green_nibble, in_data.blue_nibble}),
    .start_new_i (in_data.start_new),
    .idle_o      (srch_idle),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (slot_free)
  );

  // Convert the stored nibbles to levels; a full-table result reports zeros.
  always_comb begin
    out_data_nxt.palette_index = res.index8;
    out_data_nxt.is_new        = res.is_new;
    out_data_nxt.table_full    = res.full;
    if (res.full) begin
      out_data_nxt.red_level   = 8'h00;
      out_data_nxt.green_level = 8'h00;
      out_data_nxt.blue_level  = 8'h00;
    end else begin
      out_data_nxt.red_level   = ucpb_pkg::nibble_level(res.key[11:8]);
      out_data_nxt.green_level = ucpb_pkg::nibble_level(res.key[7:4]);
      out_data_nxt.blue_level  = ucpb_pkg::nibble_level(res.key[3:0]);
    end
  end

  // Hold the result until the downstream side takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `UCPB_ASSERT_NOW(a_full_clean, clk, rst_n, out_valid_r && out_data_r.table_full, !out_data_r.is_new && (out_data_r.palette_index == 8'h00) && (out_data_r.red_level == 8'h00), "full result carries data")
  `UCPB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid_r && !out_ready, out_valid_r && $stable(out_data_r), "result dropped or changed while stalled")
  `UCPB_ASSERT_NEXT(a_busy_after_acc, clk, rst_n, in_acc, !in_ready, "input accepted while item in flight")

endmodule

`default_nettype wire

>>> hw/rtl/ucpb_search.sv
// Colour table, used count and the sequencer that scans it with one comparator.
`default_nettype none

`include "unique_color_palette_builder_unit_macros.svh"

module ucpb_search #(
  parameter int TABLE_DEPTH = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  acc_i,
  input  wire logic [11:0]           key_i,
  input  wire logic                  start_new_i,
  output logic                       idle_o,
  output logic                       res_valid_o,
  output ucpb_pkg::srch_res_t        res_o,
  input  wire logic                  res_take_i
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       used_count_r, used_count_nxt;
  logic [CNT_W-1:0]       idx_r, idx_nxt;
  logic [11:0]            key_r, key_nxt;
  logic                   cmp_v_r, cmp_v_nxt;
  logic [IDX_W-1:0]       cmp_idx_r;
  logic [11:0]            rdata_r;
  ucpb_pkg::srch_res_t    res_r, res_nxt;

  logic                   rd_en;
  logic                   wr_en;
  logic                   hit_w;
  logic                   miss_w;
  logic                   full_w;
  logic [IDX_W+7:0]       cmp_idx_ext;
  logic [CNT_W+7:0]       cnt_ext;

  logic [11:0] mem [TABLE_DEPTH];

  assign rd_en  = (state_r == ST_SCAN) && (idx_r < used_count_r);
  assign hit_w  = (state_r == ST_SCAN) && cmp_v_r && (rdata_r == key_r);
  assign miss_w = (state_r == ST_SCAN) && !cmp_v_r && !rd_en;
  assign full_w = (used_count_r == CNT_W'(TABLE_DEPTH));

  assign cmp_idx_ext = {8'h00, cmp_idx_r};
  assign cnt_ext     = {8'h00, used_count_r};

  always_comb begin
    state_nxt      = state_r;
    used_count_nxt = used_count_r;
    idx_nxt        = idx_r;
    key_nxt        = key_r;
    cmp_v_nxt      = 1'b0;
    res_nxt        = res_r;
    wr_en          = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (acc_i) begin
          state_nxt = ST_SCAN;
          idx_nxt   = '0;
          key_nxt   = key_i;
          if (start_new_i) used_count_nxt = '0;
        end
      end
      ST_SCAN: begin
        cmp_v_nxt = rd_en;
        if (rd_en) idx_nxt = idx_r + CNT_W'(1);
        if (hit_w) begin
          state_nxt      = ST_DONE;
          res_nxt.key    = key_r;
          res_nxt.index8 = cmp_idx_ext[7:0];
          res_nxt.is_new = 1'b0;
          res_nxt.full   = 1'b0;
        end else if (miss_w) begin
          state_nxt   = ST_DONE;
          res_nxt.key = key_r;
          if (full_w) begin
            res_nxt.index8 = 8'h00;
            res_nxt.is_new = 1'b0;
            res_nxt.full   = 1'b1;
          end else begin
            wr_en          = 1'b1;
            used_count_nxt = used_count_r + CNT_W'(1);
            res_nxt.index8 = cnt_ext[7:0];
            res_nxt.is_new = 1'b1;
            res_nxt.full   = 1'b0;
          end
        end
      end
      ST_DONE: begin
        if (res_take_i) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      used_count_r <= '0;
      cmp_v_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      used_count_r <= used_count_nxt;
      cmp_v_r      <= cmp_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    key_r <= key_nxt;
    res_r <= res_nxt;
    if (rd_en) cmp_idx_r <= idx_r[IDX_W-1:0];
  end

  // Table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) mem[used_count_r[IDX_W-1:0]] <= key_r;
    if (rd_en) rdata_r <= mem[idx_r[IDX_W-1:0]];
  end

  assign idle_o      = (state_r == ST_IDLE);
  assign res_valid_o = (state_r == ST_DONE);
  assign res_o       = res_r;

  `UCPB_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, used_count_r <= CNT_W'(TABLE_DEPTH), "used count past table depth")
  `UCPB_ASSERT_NEXT(a_alloc_inc, clk, rst_n, miss_w && !full_w, used_count_r == $past(used_count_r) + CNT_W'(1), "allocation did not advance count")
  `UCPB_ASSERT_NEXT(a_res_hold, clk, rst_n, (state_r == ST_DONE) && !res_take_i, (state_r == ST_DONE) && $stable(res_r), "pending result lost")

endmodule

`default_nettype wire

>>> dv/tb_unique_color_palette_builder_unit.sv
// Self-checking testbench for the unique colour palette builder unit.
`default_nettype none

module tb_unique_color_palette_builder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PALETTE_DEPTH = 256;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  ucpb_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  ucpb_pkg::out_item_t out_data;

  // Predictor state: stored colours packed as red, green, blue nibbles.
  bit [11:0]   stored_colours [PALETTE_DEPTH];
  int unsigned colours_used;

  // Expected results, oldest first, and the run's tallies.
  ucpb_pkg::out_item_t palette_q [$];
  ucpb_pkg::out_item_t oldest_palette;
  int unsigned mismatches;
  int unsigned entries_sent;
  int unsigned results_checked;
  int unsigned new_slots;
  int unsigned repeat_hits;
  int unsigned full_refusals;
  int unsigned conversions;

  // Percentage chance per cycle that the sender holds off or the receiver stalls.
  int unsigned idle_pct = 8;
  int unsigned stall_pct = 8;

  unique_color_palette_builder_unit #(
    .TABLE_DEPTH(PALETTE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run: under 1000 entries, each with a
  // full table search plus stalls.
  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

  // Resistor-weighted DAC: each set bit of the gun nibble adds its weight.
  function automatic bit [7:0] gun_level(input bit [3:0] n);
    return (n[0] ? 8'h0e : 8'h00) + (n[1] ? 8'h1f : 8'h00)
         + (n[2] ? 8'h43 : 8'h00) + (n[3] ? 8'h8f : 8'h00);
  endfunction

  // Work out the palette result of one transferred entry and advance the
  // predictor's table exactly as the block should.
  function automatic ucpb_pkg::out_item_t resolve_palette_entry(input ucpb_pkg::in_item_t item);
    bit [11:0]           colour;
    int                  slot;
    ucpb_pkg::out_item_t res;
    colour = {item.red_nibble, item.green_nibble, item.blue_nibble};
    res    = '0;
    slot   = -1;
    // A start flag forgets the table; old contents stay but are never searched.
    if (item.start_new) begin
      colours_used = 0;
      conversions++;
    end
    for (int j = 0; j < PALETTE_DEPTH; j++) begin
      if (slot < 0 && j < colours_used && stored_colours[j] == colour) slot = j;
    end
    if (slot < 0 && colours_used >= PALETTE_DEPTH) begin
      // No match and no room: refuse with everything zero but the full flag.
      res.table_full = 1'b1;
      full_refusals++;
      return res;
    end
    if (slot < 0) begin
      slot = colours_used;
      stored_colours[slot] = colour;
      colours_used++;
      res.is_new = 1'b1;
      new_slots++;
    end else begin
      repeat_hits++;
    end
    res.palette_index = slot[7:0];
    res.red_level     = gun_level(item.red_nibble);
    res.green_level   = gun_level(item.green_nibble);
    res.blue_level    = gun_level(item.blue_nibble);
    return res;
  endfunction

  // Offer one PROM entry; called at a falling edge and returns at one.
  task automatic send_colour(input bit [3:0] r, input bit [3:0] g, input bit [3:0] b,
                             input bit start);
    ucpb_pkg::in_item_t item;
    item.red_nibble   = r;
    item.green_nibble = g;
    item.blue_nibble  = b;
    item.start_new    = start;
    // Hold off at random before raising valid.
    while ($urandom_range(0, 99) < idle_pct) @(negedge clk);
    in_data  = item;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    palette_q.push_back(resolve_palette_entry(item));
    entries_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_key(input bit [11:0] key, input bit start);
    send_colour(key[11:8], key[7:4], key[3:0], start);
  endtask

  // Receiver: stall at random, changing ready only on the falling edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic compare_field(input string field, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // Check every result transfer against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (palette_q.size() == 0) begin
        mismatches++;
        $display("%0t: result transfer with nothing expected, actual %p", $time, out_data);
      end else begin
        oldest_palette = palette_q.pop_front();
        results_checked++;
        compare_field("palette_index", oldest_palette.palette_index, out_data.palette_index);
        compare_field("is_new", oldest_palette.is_new, out_data.is_new);
        compare_field("red_level", oldest_palette.red_level, out_data.red_level);
        compare_field("green_level", oldest_palette.green_level, out_data.green_level);
        compare_field("blue_level", oldest_palette.blue_level, out_data.blue_level);
        compare_field("table_full", oldest_palette.table_full, out_data.table_full);
      end
    end
  end

  // Extremes of each gun, every weight bit alone, repeats hitting the table,
  // and the first entry after reset sent without a start flag.
  task automatic test_level_extremes();
    send_colour(4'h0, 4'h0, 4'h0, 1'b0);
    send_colour(4'hf, 4'hf, 4'hf, 1'b0);
    for (int k = 0; k < 4; k++) begin
      send_colour(4'(1 << k), 4'h0, 4'h0, 1'b0);
      send_colour(4'h0, 4'(1 << k), 4'h0, 1'b0);
      send_colour(4'h0, 4'h0, 4'(1 << k), 1'b0);
    end
    send_colour(4'h0, 4'h0, 4'h0, 1'b0);
    send_colour(4'hf, 4'hf, 4'hf, 1'b0);
    send_colour(4'h8, 4'h0, 4'h0, 1'b0);
  endtask

  // Start flag: the table restarts at slot 0 and stale slots are not matched.
  task automatic test_start_flag();
    send_colour(4'hf, 4'hf, 4'hf, 1'b1);
    send_colour(4'h0, 4'h0, 4'h0, 1'b0);
    send_colour(4'h0, 4'h0, 4'h0, 1'b1);
    send_colour(4'hf, 4'hf, 4'hf, 1'b0);
    send_colour(4'hf, 4'hf, 4'hf, 1'b0);
  endtask

  // Fill every slot with distinct colours, then mix hits (top slot among
  // them) with refusals, and finally clear a full table with a start flag.
  task automatic test_table_full();
    bit [11:0] filled [PALETTE_DEPTH];
    bit        taken [4096];
    bit [11:0] key;
    for (int j = 0; j < PALETTE_DEPTH; j++) begin
      do key = 12'($urandom_range(0, 4095)); while (taken[key]);
      taken[key] = 1'b1;
      filled[j]  = key;
      send_key(key, j == 0);
    end
    send_key(filled[PALETTE_DEPTH-1], 1'b0);
    for (int j = 0; j < 16; j++) begin
      if ($urandom_range(0, 1)) begin
        send_key(filled[$urandom_range(0, PALETTE_DEPTH - 1)], 1'b0);
      end else begin
        do key = 12'($urandom_range(0, 4095)); while (taken[key]);
        send_key(key, 1'b0);
      end
    end
    send_key(filled[0], 1'b0);
    send_key(filled[PALETTE_DEPTH-1], 1'b1);
    send_key(filled[0], 1'b0);
  endtask

  // Conversions of random length over a small colour pool so that hits are
  // common; a few stray start flags and off-pool colours break the runs.
  task automatic test_random_conversions(input int unsigned target);
    bit [11:0]   pool [$];
    int unsigned run_len;
    int unsigned pool_size;
    int unsigned roll;
    while (entries_sent < target) begin
      // Turn idling and stalls back on once more than 200 entries have been sent in total.
      if (entries_sent > 200) begin
        idle_pct  = 8;
        stall_pct = 8;
      end
      pool.delete();
      pool_size = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200)
                                              : $urandom_range(1, 24);
      for (int j = 0; j < pool_size; j++) pool.push_back(12'($urandom_range(0, 4095)));
      run_len = $urandom_range(1, 60);
      for (int j = 0; j < run_len; j++) begin
        roll = $urandom_range(0, 99);
        if (roll < 8)
          send_key(12'($urandom), j == 0);
        else
          send_key(pool[$urandom_range(0, pool_size - 1)], j == 0 || roll >= 96);
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_level_extremes();
    test_start_flag();
    test_table_full();
    idle_pct  = 0;
    stall_pct = 0;
    test_random_conversions(entries_sent + 620);

    // Drain, then allow one full table search for anything stray to appear.
    while (palette_q.size() != 0) @(posedge clk);
    repeat (PALETTE_DEPTH + 8) @(posedge clk);

    $display("Transferred %0d colour entries over %0d conversions; checked %0d results.",
             entries_sent, conversions, results_checked);
    $display("Outcomes: %0d new slots, %0d repeat hits, %0d refusals on a full table.",
             new_slots, repeat_hits, full_refusals);
    if (mismatches == 0 && palette_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
